[rtl/core/rlad_pkg.sv]
// Shared types and constants for the run-length ARGB span decoder.
package rlad_pkg;

  localparam int CoordBitsDefault = 16;
  localparam int MapWidthBits     = 13;
  localparam int CmdFifoDepth     = 4;
  localparam int OutFifoDepth     = 2;

  // Item kinds on the input channel
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_MAP_WIDTH    = 3'd2;
  localparam logic [2:0] REG_CLIP_LEFT    = 3'd3;
  localparam logic [2:0] REG_CLIP_RIGHT   = 3'd4;
  localparam logic [2:0] REG_CLIP_TOP     = 3'd5;
  localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd6;
  localparam logic [2:0] REG_GLOBAL_ALPHA = 3'd7;

  localparam logic [MapWidthBits-1:0] MapWidthReset   = 13'd1;
  localparam logic [7:0]              GlobalAlphaReset = 8'd255;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       per_pixel_alpha;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] span_x;
    logic signed [15:0] span_y;
    logic [7:0]         span_length;
    logic [23:0]        span_color;
    logic [7:0]         blend_alpha;
  } span_t;

endpackage

[rtl/core/rlad_fifo.sv]
// Small register-based FIFO used for the command queue and the result queue.
module rlad_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/rlad_front.sv]
// Front end: parses the compressed byte stream and issues span candidates.
module rlad_front #(
  parameter  int COORD_BITS = rlad_pkg::CoordBitsDefault,
  localparam int XW    = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2,
  localparam int CMD_W = XW + 16 + 8 + 24 + 8 + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 take_i,
  input  rlad_pkg::in_item_t                   item_i,
  input  logic signed [COORD_BITS-1:0]         origin_x_i,
  input  logic signed [COORD_BITS-1:0]         origin_y_i,
  input  logic signed [COORD_BITS-1:0]         clip_top_i,
  input  logic signed [COORD_BITS-1:0]         clip_bottom_i,
  input  logic [rlad_pkg::MapWidthBits-1:0]    map_width_i,
  output logic                                 cmd_push_o,
  output logic [CMD_W-1:0]                     cmd_o
);
  import rlad_pkg::*;

  localparam int RW = COORD_BITS + 2;
  localparam int CLW = 14;

  localparam logic PH_COUNT = 1'b0;
  localparam logic PH_PIXEL = 1'b1;

  logic                 phase_q, phase_d;
  logic                 rep_q, rep_d;
  logic [7:0]           left_q, left_d;
  logic [1:0]           slot_q, slot_d;
  logic [23:0]          color_q, color_d;
  logic [CLW-1:0]       col_q, col_d;
  logic signed [RW-1:0] row_q, row_d;
  logic                 skip_q, skip_d;
  logic                 fin_q, fin_d;
  logic                 mode_q, mode_d;

  logic                 row_load;
  logic signed [RW-1:0] row_src;
  logic [7:0]           b;
  logic [7:0]           len;
  logic [7:0]           left_dec;
  logic [CLW-1:0]       col_sum;
  logic                 pkt_done;
  logic signed [XW-1:0] x0;
  logic signed [15:0]   row16;

  assign b     = item_i.data_byte;
  assign len   = rep_q ? left_q : 8'd1;
  assign x0    = XW'(origin_x_i) + XW'(col_q);
  assign row16 = 16'(row_q);
  assign cmd_o = {x0, row16, len, color_q, b, mode_q};

  always_comb begin
    phase_d    = phase_q;
    rep_d      = rep_q;
    left_d     = left_q;
    slot_d     = slot_q;
    color_d    = color_q;
    col_d      = col_q;
    mode_d     = mode_q;
    row_load   = 1'b0;
    row_src    = row_q + RW'(1);
    pkt_done   = 1'b0;
    cmd_push_o = 1'b0;
    left_dec   = left_q - 8'd1;
    col_sum    = col_q + CLW'(len);

    if (take_i) begin
      if (item_i.kind == KIND_START) begin
        mode_d   = item_i.per_pixel_alpha;
        phase_d  = PH_COUNT;
        rep_d    = 1'b0;
        left_d   = '0;
        slot_d   = '0;
        col_d    = '0;
        row_load = 1'b1;
        row_src  = RW'(origin_y_i);
      end else if (!fin_q) begin
        if (phase_q == PH_COUNT) begin
          rep_d   = b[7];
          left_d  = b[7] ? ({1'b0, b[6:0]} + 8'd1) : (b + 8'd1);
          phase_d = PH_PIXEL;
          slot_d  = '0;
        end else if (slot_q != 2'd3) begin
          color_d[slot_q*8 +: 8] = b;
          slot_d = slot_q + 2'd1;
        end else begin
          // alpha byte closes the pixel
          cmd_push_o = !skip_q && (!mode_q || b != 8'd0);
          col_d      = col_sum;
          if (rep_q) begin
            left_d   = '0;
            pkt_done = 1'b1;
          end else begin
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              pkt_done = 1'b1;
            end else begin
              slot_d = '0;
            end
          end
          if (pkt_done) begin
            phase_d = PH_COUNT;
            slot_d  = '0;
            if (col_sum >= CLW'(map_width_i)) begin
              col_d    = '0;
              row_load = 1'b1;
            end
          end
        end
      end
    end

    row_d  = row_q;
    skip_d = skip_q;
    fin_d  = fin_q;
    if (row_load) begin
      row_d  = row_src;
      skip_d = row_src < RW'(clip_top_i);
      fin_d  = !skip_d && (row_src > RW'(clip_bottom_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      rep_q   <= 1'b0;
      left_q  <= '0;
      slot_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      skip_q  <= 1'b0;
      fin_q   <= 1'b1;
      mode_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rep_q   <= rep_d;
      left_q  <= left_d;
      slot_q  <= slot_d;
      col_q   <= col_d;
      row_q   <= row_d;
      skip_q  <= skip_d;
      fin_q   <= fin_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

endmodule

[rtl/core/rlad_back.sv]
// Back end: clips span candidates, scales alpha and forms result items.
module rlad_back #(
  parameter  int COORD_BITS = rlad_pkg::CoordBitsDefault,
  localparam int XW    = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2,
  localparam int CMD_W = XW + 16 + 8 + 24 + 8 + 1
) (
  input  logic                         cmd_empty_i,
  input  logic [CMD_W-1:0]             cmd_i,
  output logic                         cmd_pop_o,
  input  logic                         out_full_i,
  output logic                         out_push_o,
  output rlad_pkg::span_t              span_o,
  input  logic signed [COORD_BITS-1:0] clip_left_i,
  input  logic signed [COORD_BITS-1:0] clip_right_i,
  input  logic [7:0]                   global_alpha_i
);
  import rlad_pkg::*;

  logic signed [XW-1:0] x0;
  logic signed [15:0]   row16;
  logic [7:0]           len;
  logic [23:0]          color;
  logic [7:0]           abyte;
  logic                 mode;

  logic signed [XW-1:0] cl, cr, lo, hi, hi_raw, diff;
  logic [15:0]          prod;
  logic [16:0]          scaled;
  logic                 visible;

  assign {x0, row16, len, color, abyte, mode} = cmd_i;

  assign cl     = XW'(clip_left_i);
  assign cr     = XW'(clip_right_i);
  assign hi_raw = x0 + XW'(len) - XW'(1);
  assign lo     = (x0 < cl) ? cl : x0;
  assign hi     = (hi_raw > cr) ? cr : hi_raw;
  assign diff   = hi - lo + XW'(1);

  // floor(p / 255) for p up to 255*255
  assign prod   = 16'(abyte) * 16'(global_alpha_i);
  assign scaled = 17'(prod) + 17'(prod[15:8]) + 17'd1;

  assign visible    = (global_alpha_i != 8'd0) && !(lo > hi);
  assign cmd_pop_o  = !cmd_empty_i && !out_full_i;
  assign out_push_o = cmd_pop_o && visible;

  always_comb begin
    span_o.span_x      = 16'(lo);
    span_o.span_y      = row16;
    span_o.span_length = diff[7:0];
    span_o.span_color  = color;
    span_o.blend_alpha = mode ? scaled[15:8] : global_alpha_i;
  end

endmodule

[rtl/core/rle_argb_pixelmap_span_decoder.sv]
// Top level of the run-length ARGB pixelmap span decoder.
//
// Input channel: push / full. One compressed byte (or a start marker) per
// item; an item is taken on a clock edge with push high and full low.
// A start item (kind 0) restarts parsing and latches the alpha mode.
// Result channel: empty / pop. While empty is low, span_o holds the oldest
// span command; it is taken on an edge with pop high.
// Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
// ready is always high, write only while the decoder is idle.
// Throughput: one byte per cycle while full is low. The parser keeps all
// packet state in registers and hands each completed pixel to a 4-entry
// command queue; the clip and alpha stage drains one command per cycle,
// while the result queue has room, into a 2-entry result queue. A span is
// registered in the command queue, then the result queue, before output.
// When pop stays low the result queue fills, then the command queue, and
// full rises; no item is lost.
// Reset: both queues empty, parser finished until a start item arrives,
// registers at their defaults (map width 1, global alpha 255, others 0).
module rle_argb_pixelmap_span_decoder #(
  parameter  int COORD_BITS = rlad_pkg::CoordBitsDefault,
  localparam int CFG_W = (COORD_BITS > rlad_pkg::MapWidthBits) ?
                         COORD_BITS : rlad_pkg::MapWidthBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  rlad_pkg::in_item_t in_item_i,
  output logic               empty,
  input  logic               pop,
  output rlad_pkg::span_t    span_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i
);
  import rlad_pkg::*;

  localparam int XW    = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2;
  localparam int CMD_W = XW + 16 + 8 + 24 + 8 + 1;

  logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic signed [COORD_BITS-1:0] clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
  logic [MapWidthBits-1:0]      map_width_q;
  logic [7:0]                   global_alpha_q;

  logic             take;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
  logic             out_push, out_full;
  span_t            span_new;
  logic [$bits(span_t)-1:0] out_rdata;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;
  assign take        = push && !full;
  assign span_o      = span_t'(out_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      map_width_q    <= MapWidthReset;
      clip_left_q    <= '0;
      clip_right_q   <= '0;
      clip_top_q     <= '0;
      clip_bottom_q  <= '0;
      global_alpha_q <= GlobalAlphaReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ORIGIN_X:     origin_x_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_ORIGIN_Y:     origin_y_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_MAP_WIDTH:    map_width_q    <= cfg_data_i[MapWidthBits-1:0];
        REG_CLIP_LEFT:    clip_left_q    <= cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_RIGHT:   clip_right_q   <= cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_TOP:     clip_top_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_BOTTOM:  clip_bottom_q  <= cfg_data_i[COORD_BITS-1:0];
        REG_GLOBAL_ALPHA: global_alpha_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  rlad_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .item_i        (in_item_i),
    .origin_x_i    (origin_x_q),
    .origin_y_i    (origin_y_q),
    .clip_top_i    (clip_top_q),
    .clip_bottom_i (clip_bottom_q),
    .map_width_i   (map_width_q),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_wdata)
  );

  rlad_fifo #(
    .W    (CMD_W),
    .DEPTH(CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_wdata),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_rdata),
    .empty_o(cmd_empty)
  );

  rlad_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_rdata),
    .cmd_pop_o     (cmd_pop),
    .out_full_i    (out_full),
    .out_push_o    (out_push),
    .span_o        (span_new),
    .clip_left_i   (clip_left_q),
    .clip_right_i  (clip_right_q),
    .global_alpha_i(global_alpha_q)
  );

  rlad_fifo #(
    .W    ($bits(span_t)),
    .DEPTH(OutFifoDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (span_new),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_rdata),
    .empty_o(empty)
  );

endmodule

[sim/rlad_span_checker.sv]
// Checker for the span decoder: predicts spans from accepted items and compares results.
module rlad_span_checker #(
  parameter int CfgW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  rlad_pkg::in_item_t in_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  rlad_pkg::span_t    span_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 spans_seen_o
);
  import rlad_pkg::*;

  typedef enum logic {AwaitCount, AwaitPixel} parse_e;

  localparam logic [7:0] RepeatFlag = 8'h80;

  // register copies
  logic signed [CoordBitsDefault-1:0] org_x, org_y, clip_l, clip_r, clip_t, clip_b;
  logic [MapWidthBits-1:0]            map_w;
  logic [7:0]                         glob_alpha;

  // parser copy
  parse_e      phase;
  bit          is_run;
  int unsigned px_left;
  int unsigned slot;
  logic [23:0] color_acc;
  longint      col, row;
  bit          skipping, halted, use_pixel_alpha;

  span_t spans_due[$];
  int    fails, seen;

  function automatic void reset_model();
    org_x = '0; org_y = '0; clip_l = '0; clip_r = '0; clip_t = '0; clip_b = '0;
    map_w = MapWidthReset;
    glob_alpha = GlobalAlphaReset;
    phase = AwaitCount; is_run = 0; px_left = 0; slot = 0; color_acc = '0;
    col = 0; row = 0; skipping = 0; halted = 1; use_pixel_alpha = 0;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [CfgW-1:0] val);
    case (idx)
      REG_ORIGIN_X:     org_x = val[CoordBitsDefault-1:0];
      REG_ORIGIN_Y:     org_y = val[CoordBitsDefault-1:0];
      REG_MAP_WIDTH:    map_w = val[MapWidthBits-1:0];
      REG_CLIP_LEFT:    clip_l = val[CoordBitsDefault-1:0];
      REG_CLIP_RIGHT:   clip_r = val[CoordBitsDefault-1:0];
      REG_CLIP_TOP:     clip_t = val[CoordBitsDefault-1:0];
      REG_CLIP_BOTTOM:  clip_b = val[CoordBitsDefault-1:0];
      REG_GLOBAL_ALPHA: glob_alpha = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic void set_row_flags();
    skipping = row < clip_t;
    halted   = !skipping && row > clip_b;
  endfunction

  // overshoot past the row end is dropped, not wrapped
  function automatic void close_packet();
    phase = AwaitCount;
    slot  = 0;
    if (col >= longint'(map_w)) begin
      col = 0;
      row++;
      set_row_flags();
    end
  endfunction

  function automatic void queue_span(longint x0, int unsigned len, logic [7:0] a);
    longint lo, hi;
    span_t  s;
    lo = x0;
    hi = x0 + longint'(len) - 1;
    if (glob_alpha == 8'd0) return;
    if (lo < clip_l) lo = clip_l;
    if (hi > clip_r) hi = clip_r;
    if (lo > hi) return;
    s.span_x      = lo[15:0];
    s.span_y      = row[15:0];
    s.span_length = 8'(hi - lo + 1);
    s.span_color  = color_acc;
    s.blend_alpha = a;
    spans_due.push_back(s);
  endfunction

  function automatic void take_item(in_item_t it);
    logic [7:0]  b;
    int unsigned a;
    bit          vis;
    b = it.data_byte;
    if (it.kind == KIND_START) begin
      use_pixel_alpha = it.per_pixel_alpha;
      phase = AwaitCount; is_run = 0; px_left = 0; slot = 0; color_acc = '0;
      col = 0;
      row = org_y;
      set_row_flags();
      return;
    end
    if (halted) return;
    if (phase == AwaitCount) begin
      is_run    = (b & RepeatFlag) != 0;
      px_left   = is_run ? b[6:0] + 1 : b + 1;
      phase     = AwaitPixel;
      slot      = 0;
      color_acc = '0;
      return;
    end
    if (slot < 3) begin
      color_acc = color_acc | (24'(b) << (8 * slot));
      slot++;
      return;
    end
    // fourth byte is the pixel's alpha
    a   = use_pixel_alpha ? (32'(b) * 32'(glob_alpha)) / 255 : 32'(glob_alpha);
    vis = !skipping && (!use_pixel_alpha || b != 8'd0);
    if (is_run) begin
      if (vis) queue_span(longint'(org_x) + col, px_left, a[7:0]);
      col += px_left;
      px_left = 0;
      close_packet();
    end else begin
      if (vis) queue_span(longint'(org_x) + col, 1, a[7:0]);
      col++;
      px_left = (px_left - 1) & 32'hff;
      if (px_left == 0) begin
        close_packet();
      end else begin
        slot = 0;
        color_acc = '0;
      end
    end
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_span(span_t got);
    span_t want;
    seen++;
    if (spans_due.size() == 0) begin
      $error("span with none expected: x=%0d y=%0d len=%0d color=%h alpha=%0d",
             got.span_x, got.span_y, got.span_length, got.span_color, got.blend_alpha);
      fails++;
      return;
    end
    want = spans_due.pop_front();
    check_field("span_x", want.span_x, got.span_x);
    check_field("span_y", want.span_y, got.span_y);
    check_field("span_length", want.span_length, got.span_length);
    check_field("span_color", want.span_color, got.span_color);
    check_field("blend_alpha", want.blend_alpha, got.blend_alpha);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      spans_due.delete();
      fails = 0;
      seen  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      spans_seen_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      if (push_i && !full_i) take_item(in_item_i);
      if (pop_i && !empty_i) check_span(span_i);
      fail_count_o <= fails;
      pending_o    <= spans_due.size();
      spans_seen_o <= seen;
    end
  end

endmodule

[sim/tb.sv]
// Testbench top for the span decoder: stimulus, handshake pacing and verdict.
module tb;
  import rlad_pkg::*;

  localparam int CfgW = (CoordBitsDefault > MapWidthBits) ? CoordBitsDefault : MapWidthBits;
  localparam int ItemGoal   = 450;
  localparam int CycleLimit = 500000;
  localparam logic [7:0] RepeatFlag = 8'h80;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            push = 1'b0;
  logic            full;
  in_item_t        in_item = '0;
  logic            empty;
  logic            pop = 1'b0;
  span_t           span;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [2:0]      cfg_index = REG_ORIGIN_X;
  logic [CfgW-1:0] cfg_data = '0;

  int fail_count, pending, spans_seen;
  int cycle_count = 0;
  int sent = 0;
  int idle_odds = 4;
  bit calm = 0;

  rle_argb_pixelmap_span_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .span_o      (span),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rlad_span_checker #(.CfgW(CfgW)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .span_i       (span),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .spans_seen_o (spans_seen)
  );

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL rle_argb_pixelmap_span_decoder");
    $finish;
  end

  task automatic idle_in(int n);
    @(negedge clk_i) push <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send(logic kind, logic [7:0] b, logic ppa);
    if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
      idle_in($urandom_range(1, 6));
    @(negedge clk_i);
    push    <= 1'b1;
    in_item <= '{kind: kind, data_byte: b, per_pixel_alpha: ppa};
    do @(posedge clk_i); while (full);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgW'(val);
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic configure(int ox, int oy, int mw, int cl, int cr, int ct, int cb, int ga);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_CLIP_LEFT, cl);
    write_reg(REG_CLIP_RIGHT, cr);
    write_reg(REG_CLIP_TOP, ct);
    write_reg(REG_CLIP_BOTTOM, cb);
    write_reg(REG_GLOBAL_ALPHA, ga);
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  // no spans outstanding, then room for items that make none to drain
  task automatic settle();
    @(negedge clk_i) push <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic send_pixel();
    int r;
    logic [7:0] a;
    repeat (3) send(KIND_DATA, 8'($urandom), 1'($urandom));
    r = $urandom_range(0, 4);
    a = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
    send(KIND_DATA, a, 1'($urandom));
  endtask

  task automatic send_packet();
    int n;
    if ($urandom_range(0, 1) == 1) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 9);
      send(KIND_DATA, RepeatFlag | 8'(n), 1'($urandom));
      send_pixel();
    end else begin
      n = ($urandom_range(0, 40) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
      send(KIND_DATA, 8'(n), 1'($urandom));
      repeat (n + 1) send_pixel();
    end
  endtask

  // stray bytes, a packet cut short by a start, or a bare restart
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(1, 5)) send(KIND_DATA, 8'($urandom), 1'($urandom));
      1: begin
        send(KIND_DATA, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 3)) send(KIND_DATA, 8'($urandom), 1'($urandom));
        send(KIND_START, 8'($urandom), 1'($urandom));
      end
      default: send(KIND_START, 8'($urandom), 1'($urandom));
    endcase
  endtask

  task automatic pick_and_configure();
    int ox, oy, mw, cl, cr, ct, cb, ga, r;
    if ($urandom_range(0, 5) == 0) begin
      r  = $urandom_range(0, 2);
      ox = (r == 0) ? -32768 : (r == 1) ? 32767 : 0;
      r  = $urandom_range(0, 2);
      oy = (r == 0) ? -32768 : (r == 1) ? 32767 : -2;
      r  = $urandom_range(0, 3);
      mw = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 4096 : 8191;
      if ($urandom_range(0, 1) == 1) begin
        cl = -32768; cr = 32767; ct = -32768; cb = 32767;
      end else begin
        cl = 32760; cr = 32767; ct = oy; cb = oy + 3;
      end
    end else begin
      ox = int'($urandom_range(0, 80)) - 40;
      oy = int'($urandom_range(0, 8)) - 4;
      mw = $urandom_range(1, 24);
      cl = int'($urandom_range(0, 40)) - 20;
      cr = cl + int'($urandom_range(0, 140)) - 5;
      ct = int'($urandom_range(0, 6)) - 3;
      cb = ct + int'($urandom_range(0, 12)) - 1;
    end
    r  = $urandom_range(0, 7);
    ga = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 254);
    configure(ox, oy, mw, cl, cr, ct, cb, ga);
  endtask

  // result side: random stalls, plus one long hold while items keep coming
  initial begin
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && spans_seen >= 30 && push) begin
        held = 1;
        repeat (120) @(negedge clk_i) pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) @(negedge clk_i) pop <= 1'b0;
      end else begin
        @(negedge clk_i) pop <= 1'b1;
      end
    end
  end

  initial begin
    int phases;
    phases = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // map width 0 ends a row after every packet; top row is above the clip
    configure(3, -1, 0, 0, 100, 0, 1, 255);
    send(KIND_DATA, 8'hff, 1'b1);                  // never started: ignored
    send(KIND_START, 8'h00, 1'b1);
    send(KIND_DATA, RepeatFlag, 1'b0);             // run on a skipped row
    send(KIND_DATA, 8'h11, 1'b0);
    send(KIND_DATA, 8'h22, 1'b0);
    send(KIND_DATA, 8'h33, 1'b0);
    send(KIND_DATA, 8'hff, 1'b0);
    send(KIND_DATA, 8'hff, 1'b0);                  // longest run, clipped right
    send(KIND_DATA, 8'hff, 1'b1);
    send(KIND_DATA, 8'h00, 1'b0);
    send(KIND_DATA, 8'hff, 1'b1);
    send(KIND_DATA, 8'hff, 1'b0);
    send(KIND_DATA, 8'h01, 1'b0);                  // two literals, first transparent
    repeat (4) send(KIND_DATA, 8'h00, 1'b1);
    send(KIND_DATA, 8'hff, 1'b0);
    send(KIND_DATA, 8'hff, 1'b0);
    send(KIND_DATA, 8'hff, 1'b0);
    send(KIND_DATA, 8'h80, 1'b0);
    send(KIND_DATA, 8'h81, 1'b1);                  // past the clip bottom: ignored

    while ((sent < ItemGoal || spans_seen < 60) && phases < 100) begin
      phases++;
      settle();
      pick_and_configure();
      idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 4;
      send(KIND_START, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_packet();
      end
      if (sent >= ItemGoal - 80) calm = 1;
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("PASS rle_argb_pixelmap_span_decoder");
    else
      $display("FAIL rle_argb_pixelmap_span_decoder");
    $finish;
  end

endmodule
